/* design/i2a_pkg.sv */
// Shared types and constants for the integer to ASCII formatter.
// Holds the job record passed from the front end to the back end, the back-end states,
// the character codes and the hex digit helper. No dependencies.
package i2a_pkg;

    localparam int VALUE_W    = 32;
    localparam int DEC_DIGITS = 10;
    localparam int BCD_W      = 4 * DEC_DIGITS;

    localparam logic [3:0] WIDTH_MAX = 4'd9;

    localparam logic KIND_DEC = 1'b0;
    localparam logic KIND_PTR = 1'b1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // One formatting job after classification.
    typedef struct packed {
        logic [VALUE_W-1:0] mag;      // magnitude (decimal) or raw word (pointer)
        logic               neg;
        logic               kind;
        logic [3:0]         width;    // saturated to WIDTH_MAX
        logic               zero_pad;
        logic [3:0]         hex_nd;   // significant hex digits, 1..8
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_EMIT
    } t_state;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = CH_LOW_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

/* design/i2a_front.sv */
// Front end of the formatter: accepts input beats and classifies them into jobs.
// Forms sign and magnitude, saturates the width and counts hex digits.
// Depends on i2a_pkg.
module i2a_front
    import i2a_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_value,
    input  logic        i_kind,
    input  logic [3:0]  i_width,
    input  logic        i_zero_pad,
    output logic        o_push,
    output t_job        o_job,
    input  logic        i_full
);

    logic r_valid;
    t_job r_job;
    t_job n_job;
    logic accept;

    assign o_in_stall = r_valid && i_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_full;
    assign o_job      = r_job;

    always_comb begin
        n_job.kind     = i_kind;
        n_job.neg      = (i_kind == KIND_DEC) && i_value[31];
        n_job.mag      = n_job.neg ? (32'd0 - i_value) : i_value;
        n_job.width    = (i_width > WIDTH_MAX) ? WIDTH_MAX : i_width;
        n_job.zero_pad = i_zero_pad;
        n_job.hex_nd   = 4'd1;
        for (int i = 1; i < 8; i++) begin
            if (i_value[i*4 +: 4] != 4'd0) begin
                n_job.hex_nd = 4'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && i_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

/* design/i2a_queue.sv */
// Two-entry job queue between the front end and the back end.
// Lets either side stall on its own. Depends on i2a_pkg.
module i2a_queue
    import i2a_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("queue read while empty");

endmodule

/* design/i2a_back.sv */
// Back end of the formatter: bit-serial binary to BCD, digit count, character emit.
// Drives the registered output channel. Depends on i2a_pkg.
module i2a_back
    import i2a_pkg::*;
#(
    parameter int PTR_MIN_DIGITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_char_code,
    output logic       o_last_char
);

    localparam int PTR_LEN = 2 + ((PTR_MIN_DIGITS > 8) ? PTR_MIN_DIGITS : 8);
    localparam int MAX_LEN = (PTR_LEN > DEC_DIGITS + 1) ? PTR_LEN : DEC_DIGITS + 1;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int POS_W   = $clog2(MAX_LEN);

    t_state             r_state;
    t_state             n_state;
    t_job               r_job;
    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   n_bcd;
    logic [4:0]         r_cnt;
    logic [3:0]         r_nd;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_top;
    logic               r_out_valid;
    logic [7:0]         r_char;
    logic               r_last;

    logic               emit_go;
    logic               out_take;
    logic [3:0]         dec_nd;
    logic [LEN_W-1:0]   dec_body;
    logic [LEN_W-1:0]   dec_len;
    logic [LEN_W-1:0]   hex_d;
    logic [LEN_W-1:0]   scan_len;
    logic [POS_W-1:0]   scan_top;
    logic [3:0]         dec_digit;
    logic [7:0]         emit_char;

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.kind == KIND_PTR) ? ST_SCAN : ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_cnt == 5'd0) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: n_state = ST_EMIT;
            ST_EMIT: begin
                if (emit_go && (r_pos == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_pop    = (r_state == ST_IDLE) && i_job_valid;
        emit_go  = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);
        out_take = r_out_valid && !i_out_stall;
    end

    // Double-dabble step: adjust every digit, then shift in the next bit.
    always_comb begin
        logic [BCD_W-1:0] adj;
        adj = r_bcd;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end
        end
        n_bcd = {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
    end

    // Text length from digit count, sign and field width, or from the hex digit count for a pointer.
    always_comb begin
        dec_nd = 4'd1;
        for (int i = 1; i < DEC_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] != 4'd0) begin
                dec_nd = 4'(i + 1);
            end
        end
        dec_body = LEN_W'(dec_nd) + LEN_W'(r_job.neg);
        dec_len  = (dec_body > LEN_W'(r_job.width)) ? dec_body : LEN_W'(r_job.width);
        hex_d    = (LEN_W'(r_job.hex_nd) > LEN_W'(PTR_MIN_DIGITS)) ?
                   LEN_W'(r_job.hex_nd) : LEN_W'(PTR_MIN_DIGITS);
        scan_len = (r_job.kind == KIND_PTR) ? (hex_d + LEN_W'(2)) : dec_len;
        scan_top = POS_W'(scan_len - LEN_W'(1));
    end

    always_comb begin
        case (r_pos[3:0])
            4'd0:    dec_digit = r_bcd[3:0];
            4'd1:    dec_digit = r_bcd[7:4];
            4'd2:    dec_digit = r_bcd[11:8];
            4'd3:    dec_digit = r_bcd[15:12];
            4'd4:    dec_digit = r_bcd[19:16];
            4'd5:    dec_digit = r_bcd[23:20];
            4'd6:    dec_digit = r_bcd[27:24];
            4'd7:    dec_digit = r_bcd[31:28];
            4'd8:    dec_digit = r_bcd[35:32];
            4'd9:    dec_digit = r_bcd[39:36];
            default: dec_digit = 4'd0;
        endcase
    end

    // Character at the current position, counted from the right end.
    always_comb begin
        if (r_job.kind == KIND_PTR) begin
            if (r_pos == r_top) begin
                emit_char = CH_ZERO;
            end else if (r_pos == r_top - POS_W'(1)) begin
                emit_char = CH_X;
            end else if (r_pos < POS_W'(8)) begin
                emit_char = hex_char(r_bin[{r_pos[2:0], 2'b00} +: 4]);
            end else begin
                emit_char = CH_ZERO;
            end
        end else if (r_pos < POS_W'(r_nd)) begin
            emit_char = CH_ZERO + {4'd0, dec_digit};
        end else if (r_job.zero_pad) begin
            emit_char = (r_job.neg && (r_pos == r_top)) ? CH_MINUS : CH_ZERO;
        end else begin
            emit_char = (r_job.neg && (r_pos == POS_W'(r_nd))) ? CH_MINUS : CH_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_bin <= i_job.mag;
            r_bcd <= '0;
            r_cnt <= 5'd31;
        end
        if (r_state == ST_CONV) begin
            r_bcd <= n_bcd;
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_cnt <= r_cnt - 5'd1;
        end
        if (r_state == ST_SCAN) begin
            r_nd  <= (r_job.kind == KIND_PTR) ? r_job.hex_nd : dec_nd;
            r_top <= scan_top;
            r_pos <= scan_top;
        end
        if (emit_go) begin
            r_char <= emit_char;
            r_last <= (r_pos == '0);
            r_pos  <= r_pos - POS_W'(1);
        end
    end

    a_conv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV && r_cnt == 5'd0) |=> (r_state == ST_SCAN))
        else $error("conversion did not finish after 32 steps");

    a_nd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_nd != 4'd0 && r_nd <= 4'd10))
        else $error("digit count out of range");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_pos <= r_top && int'(r_top) < MAX_LEN))
        else $error("emit position out of range");

endmodule

/* design/integer_to_ascii_formatter_top.sv */
// Top level of the integer to ASCII formatter.
// Instantiates i2a_front, i2a_queue and i2a_back; depends on i2a_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one beat per value: the word,
//   its kind (signed decimal or "0x" pointer), a field width and a zero-pad flag.
//   Output channel (o_out_valid / i_out_stall) sends one beat per ASCII character;
//   o_last_char marks the final character of a value's text.
//   A beat moves on a rising edge with valid high and stall low.
// Flow:
//   A beat is classified into a front register and queued (two entries).
//   The back end handles one value at a time: a decimal value is popped,
//   converted bit-serially from binary to BCD, its text sized, then its
//   characters sent while the output does not stall; L <= 11 characters.
//   A pointer value skips conversion; its length is L = 2 + max(digits,
//   PTR_MIN_DIGITS). The conversion loop sets the decimal rate.
// Reset: i_rst_n synchronous active low; empties the queue and output register.
// Stall: when i_out_stall holds, the current character is kept and the back end
//   waits; the queue fills, then o_in_stall rises.
module integer_to_ascii_formatter_top
    import i2a_pkg::*;
#(
    parameter int PTR_MIN_DIGITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_value,
    input  logic        i_kind,
    input  logic [3:0]  i_width,
    input  logic        i_zero_pad,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_char_code,
    output logic        o_last_char
);

    t_job front_job;
    t_job queue_job;
    logic push;
    logic full;
    logic pop;
    logic queue_valid;

    // Accept and classify.
    i2a_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_value    (i_value),
        .i_kind     (i_kind),
        .i_width    (i_width),
        .i_zero_pad (i_zero_pad),
        .o_push     (push),
        .o_job      (front_job),
        .i_full     (full)
    );

    // Decouple front and back.
    i2a_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_job   (queue_job)
    );

    // Convert and emit characters.
    i2a_back #(
        .PTR_MIN_DIGITS (PTR_MIN_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule

/* bench/tb_integer_to_ascii_formatter_top.sv */
// Self-checking bench for integer_to_ascii_formatter_top: formats each sent word in a
// local predictor and compares every ASCII character beat against it, in order.
// Depends on i2a_pkg for kind codes and character constants, and on the design under test.
module tb_integer_to_ascii_formatter_top
    import i2a_pkg::*;
();

    localparam int PTR_DIGITS_MIN    = 8;
    localparam int TIMEOUT_UNITS     = 4_000_000;  // far above a clean run
    localparam int END_SETTLE_CYCLES = 60;         // decimal latency plus a full text
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int MAX_REPORTED      = 10;

    // One output character beat as the predictor expects it.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char_beat;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [31:0] i_value     = '0;
    logic        i_kind      = KIND_DEC;
    logic [3:0]  i_width     = '0;
    logic        i_zero_pad  = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_char_code;
    logic        o_last_char;

    // Characters still owed by the block, oldest first.
    t_char_beat expected_chars[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_request   = 0;   // set by a test to start a long receiver hold-off
    int hold_left      = 0;
    int mismatch_count = 0;

    integer_to_ascii_formatter_top #(
        .PTR_MIN_DIGITS(PTR_DIGITS_MIN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .i_kind      (i_kind),
        .i_width     (i_width),
        .i_zero_pad  (i_zero_pad),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Build the printf-style text of one word and append its beats to the queue.
    // Decimal: space padding goes before the sign, zero padding after it; the
    // magnitude is formed unsigned so the most negative word prints in full.
    // Pointer: "0x", then lowercase hex zero-filled to the minimum digit count.
    function automatic void format_expected_text(input logic [31:0] v, input logic k,
                                                 input logic [3:0] w, input logic zp);
        logic [7:0]  digits[$];   // least significant digit first
        logic [7:0]  text[$];
        logic [31:0] rest;
        logic [3:0]  nib;
        logic        neg;
        int          field;
        int          fill;
        t_char_beat  beat;
        if (k == KIND_PTR) begin
            rest = v;
            do begin
                nib = rest[3:0];
                digits.push_back(nib < 4'd10 ? CH_ZERO + 8'(nib)
                                             : CH_LOW_A + 8'(nib) - 8'd10);
                rest = rest >> 4;
            end while (rest != 0);
            text.push_back(CH_ZERO);
            text.push_back(CH_X);
            for (int i = digits.size(); i < PTR_DIGITS_MIN; i++) text.push_back(CH_ZERO);
        end else begin
            neg  = v[31];
            rest = neg ? -v : v;
            // Zero still yields one digit.
            do begin
                digits.push_back(CH_ZERO + 8'(rest % 10));
                rest = rest / 10;
            end while (rest != 0);
            // Saturate the width; the sign counts toward it.
            field = (w > WIDTH_MAX) ? WIDTH_MAX : w;
            fill  = field - digits.size() - (neg ? 1 : 0);
            if (fill < 0) fill = 0;
            if (!zp) repeat (fill) text.push_back(CH_SPACE);
            if (neg) text.push_back(CH_MINUS);
            if (zp) repeat (fill) text.push_back(CH_ZERO);
        end
        for (int i = digits.size() - 1; i >= 0; i--) text.push_back(digits[i]);
        foreach (text[i]) begin
            beat.code = text[i];
            beat.last = (i == text.size() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    // Receiver: stall at random, or hold off for a whole requested stretch,
    // counted down here one cycle at a time.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Checker: every accepted character beat must match the oldest expectation.
    // Values sampled here are the ones that stood before this edge.
    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED)
                    $display("unexpected char beat: code %h last %b", o_char_code, o_last_char);
            end else begin
                want = expected_chars.pop_front();
                if (o_char_code !== want.code || o_last_char !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED)
                        $display("char mismatch: expected code %h last %b, got code %h last %b",
                                 want.code, want.last, o_char_code, o_last_char);
                end
            end
        end
    end

    // Offer one word. Idle first at the sender's rate, then hold the beat until
    // it is taken. Valid stays high afterwards so back-to-back beats need no
    // second assignment in one step; callers that wait drop it themselves.
    task automatic send_value(input logic [31:0] v, input logic k,
                              input logic [3:0] w, input logic zp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_kind     <= k;
        i_width    <= w;
        i_zero_pad <= zp;
        do @(posedge i_clk); while (o_in_stall);
        format_expected_text(v, k, w, zp);
    endtask

    // Drop valid and wait until every owed character has come out.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    // Random word biased toward small magnitudes, small negatives and extremes,
    // with widths mostly in range and some above the saturation point.
    task automatic send_random_value();
        logic [31:0] v;
        logic [3:0]  w;
        case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 20);
            1: v = -$urandom_range(1, 20);
            2: v = $urandom_range(0, 999_999_999);
            3: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = 32'h8000_0000;
                    default: v = 32'hffff_ffff;
                endcase
            end
            default: v = $urandom;
        endcase
        w = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(0, 9));
        send_value(v, ($urandom_range(0, 3) == 0) ? KIND_PTR : KIND_DEC, w,
                   1'($urandom_range(0, 1)));
    endtask

    // Field extremes, both kinds and each corner of padding and sign handling.
    task automatic test_directed();
        send_value(32'd0,          KIND_DEC, 4'd0,  1'b0);  // zero is one digit
        send_value(32'd0,          KIND_DEC, 4'd5,  1'b1);
        send_value(32'd1,          KIND_DEC, 4'd1,  1'b0);
        send_value(32'hffff_ffff,  KIND_DEC, 4'd0,  1'b0);  // minus one
        send_value(32'h7fff_ffff,  KIND_DEC, 4'd0,  1'b0);
        send_value(32'h8000_0000,  KIND_DEC, 4'd0,  1'b0);  // most negative
        send_value(32'h8000_0000,  KIND_DEC, 4'd9,  1'b1);
        send_value(-32'sd5,        KIND_DEC, 4'd9,  1'b0);  // spaces before sign
        send_value(-32'sd5,        KIND_DEC, 4'd9,  1'b1);  // zeros after sign
        send_value(32'd42,         KIND_DEC, 4'd15, 1'b1);  // width saturates
        send_value(32'd42,         KIND_DEC, 4'd10, 1'b0);
        send_value(32'd12345,      KIND_DEC, 4'd3,  1'b1);  // width below length
        send_value(32'd123,        KIND_DEC, 4'd3,  1'b0);  // width equals length
        send_value(32'd999_999_999,   KIND_DEC, 4'd9, 1'b1);
        send_value(32'd1_000_000_000, KIND_DEC, 4'd8, 1'b0);
        send_value(32'd0,          KIND_PTR, 4'd0,  1'b0);
        send_value(32'hffff_ffff,  KIND_PTR, 4'd0,  1'b0);
        send_value(32'hdead_beef,  KIND_PTR, 4'd15, 1'b1);  // width and pad ignored
        send_value(32'h0000_0001,  KIND_PTR, 4'd9,  1'b0);
        send_value(32'h1234_5678,  KIND_PTR, 4'd4,  1'b1);
        send_value(32'h0abc_def0,  KIND_PTR, 4'd0,  1'b0);
        wait_for_drain();
    endtask

    task automatic test_random(input int count);
        repeat (count) send_random_value();
        wait_for_drain();
    endtask

    // Hold the receiver off for a long stretch while the sender keeps offering,
    // so the queue fills and the block stalls its input.
    task automatic test_backpressure();
        hold_request = LONG_HOLD_CYCLES;
        repeat (10) send_random_value();
        wait_for_drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily.
        send_idle_pct = 22;
        recv_idle_pct = 62;
        test_directed();
        test_random(24);

        // Swap the idle rates.
        send_idle_pct = 62;
        recv_idle_pct = 22;
        test_random(25);

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(20);

        wait_for_drain();
        repeat (END_SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("tb_integer_to_ascii_formatter_top: clean");
        end else begin
            $display("tb_integer_to_ascii_formatter_top: errors");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        #TIMEOUT_UNITS;
        $display("tb_integer_to_ascii_formatter_top: errors");
        $finish;
    end

endmodule
